// File: hw/rtl/bas_pkg.sv
// ----------------------------------------------------------------------------
// bas_pkg
// Types and constants shared by the bracket-aware delimiter splitter.
// ----------------------------------------------------------------------------
package bas_pkg;

    // Opener codes held in the stack cells
    typedef enum logic [2:0] {
        CODE_SQUARE = 3'd0,
        CODE_ROUND  = 3'd1,
        CODE_CURLY  = 3'd2,
        CODE_DQUOTE = 3'd3,
        CODE_SQUOTE = 3'd4
    } t_code;

    // Per-cycle operation broadcast along the cell chain
    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_PUSH = 2'd1,
        OP_POP  = 2'd2
    } t_stack_op;

    // Characters of interest
    localparam logic [7:0] CH_LSQ    = 8'h5B; // [
    localparam logic [7:0] CH_LRND   = 8'h28; // (
    localparam logic [7:0] CH_LCRL   = 8'h7B; // {
    localparam logic [7:0] CH_RSQ    = 8'h5D; // ]
    localparam logic [7:0] CH_RRND   = 8'h29; // )
    localparam logic [7:0] CH_RCRL   = 8'h7D; // }
    localparam logic [7:0] CH_DQUOTE = 8'h22; // "
    localparam logic [7:0] CH_SQUOTE = 8'h27; // '
    localparam logic [7:0] CH_BSLASH = 8'h5C; // backslash
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [7:0] DELIM_RESET = 8'd44; // comma

    typedef struct packed {
        logic [7:0] text_char;
        logic       end_of_list;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  char_out;
        logic        piece_boundary;
        logic        mismatch;
        logic        overflow;
        logic [4:0]  nesting_depth;
        logic [15:0] char_index;
        logic        list_done;
    } t_out_item;

    typedef logic [7:0] t_cfg_item;

endpackage

// File: hw/rtl/bas_stream_if.sv
// ----------------------------------------------------------------------------
// bas_stream_if
// Valid/ready request channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface bas_stream_if #(
    parameter type T = logic [7:0]
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/bracket_aware_delimiter_split.sv
// ----------------------------------------------------------------------------
// bracket_aware_delimiter_split
// Splits a character stream at top-level delimiters while tracking nesting.
//
// One character is taken per request and one result request comes out per
// character, registered at the output; the block sustains one character per
// cycle, limited only by downstream ready. Nesting is held in a row of
// STACK_DEPTH cells that shift as a whole on push and pop, so the top of the
// stack is always cell 0 and no memory port sits in the path. Opening
// brackets push, quotes toggle (ignored right after a backslash), closing
// brackets pop on a matching opener or raise mismatch. A push against a full
// stack is dropped and raises overflow. A character equal to the delimiter
// register at depth zero, after the update, marks a piece boundary. The
// end-of-list character returns depth, previous character and index to their
// reset values; the delimiter is kept. The delimiter channel is always ready
// and should only be written while no character is in flight.
// ----------------------------------------------------------------------------
module bracket_aware_delimiter_split
    import bas_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bas_stream_if.sink   i_cfg,
    bas_stream_if.sink   i_in,
    bas_stream_if.source o_out
);

    localparam int PW = $clog2(STACK_DEPTH + 1);

    // Control state
    logic [PW-1:0] r_ptr;
    logic [7:0]    r_prev;
    logic [15:0]   r_pos;
    logic [7:0]    r_delim;

    logic [PW-1:0] n_ptr;

    t_code         w_code [STACK_DEPTH];
    t_stack_op     w_op;
    t_stack_op     w_cell_op;
    t_code         w_push_code;
    logic          w_mis;
    logic          w_ovf;
    logic          w_accept;
    logic          w_skid_ready;
    logic          w_empty;
    logic          w_full;
    logic [PW+4:0] w_depth_ext;
    t_in_item      w_in;
    t_out_item     w_res;

    assign w_in     = i_in.payload;
    assign w_accept = i_in.valid && w_skid_ready;
    assign i_in.ready  = w_skid_ready;
    assign i_cfg.ready = 1'b1;

    assign w_empty = (r_ptr == '0);
    assign w_full  = (r_ptr == PW'(STACK_DEPTH));

    // Classify the character and pick the stack operation
    always_comb begin
        logic want_push;
        want_push   = 1'b0;
        w_op        = OP_HOLD;
        w_push_code = CODE_SQUARE;
        w_mis       = 1'b0;
        w_ovf       = 1'b0;
        case (w_in.text_char)
            CH_LSQ: begin
                want_push   = 1'b1;
                w_push_code = CODE_SQUARE;
            end
            CH_LRND: begin
                want_push   = 1'b1;
                w_push_code = CODE_ROUND;
            end
            CH_LCRL: begin
                want_push   = 1'b1;
                w_push_code = CODE_CURLY;
            end
            CH_DQUOTE: begin
                if (r_prev != CH_BSLASH) begin
                    if (!w_empty && w_code[0] == CODE_DQUOTE) begin
                        w_op = OP_POP;
                    end else begin
                        want_push   = 1'b1;
                        w_push_code = CODE_DQUOTE;
                    end
                end
            end
            CH_SQUOTE: begin
                if (r_prev != CH_BSLASH) begin
                    if (!w_empty && w_code[0] == CODE_SQUOTE) begin
                        w_op = OP_POP;
                    end else begin
                        want_push   = 1'b1;
                        w_push_code = CODE_SQUOTE;
                    end
                end
            end
            CH_RSQ: begin
                if (!w_empty && w_code[0] == CODE_SQUARE) w_op = OP_POP;
                else w_mis = 1'b1;
            end
            CH_RRND: begin
                if (!w_empty && w_code[0] == CODE_ROUND) w_op = OP_POP;
                else w_mis = 1'b1;
            end
            CH_RCRL: begin
                if (!w_empty && w_code[0] == CODE_CURLY) w_op = OP_POP;
                else w_mis = 1'b1;
            end
            default: begin
            end
        endcase
        // drop a push against a full stack
        if (want_push) begin
            if (w_full) w_ovf = 1'b1;
            else w_op = OP_PUSH;
        end
    end

    always_comb begin
        case (w_op)
            OP_PUSH: n_ptr = r_ptr + 1'b1;
            OP_POP:  n_ptr = r_ptr - 1'b1;
            default: n_ptr = r_ptr;
        endcase
    end

    assign w_cell_op = w_accept ? w_op : OP_HOLD;

    // Stack cells: cell 0 is the top, pushes shift the row downwards
    for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
        t_code w_above;
        t_code w_below;
        if (k == 0) begin : g_top
            assign w_above = w_push_code;
        end else begin : g_mid
            assign w_above = w_code[k-1];
        end
        if (k == STACK_DEPTH - 1) begin : g_last
            assign w_below = w_code[k];
        end else begin : g_inner
            assign w_below = w_code[k+1];
        end
        bas_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (w_cell_op),
            .i_above (w_above),
            .i_below (w_below),
            .o_code  (w_code[k])
        );
    end

    // Depth is reported modulo 32
    assign w_depth_ext = {5'd0, n_ptr};

    always_comb begin
        w_res.char_out       = w_in.text_char;
        w_res.piece_boundary = (w_in.text_char == r_delim) && (n_ptr == '0);
        w_res.mismatch       = w_mis;
        w_res.overflow       = w_ovf;
        w_res.nesting_depth  = w_depth_ext[4:0];
        w_res.char_index     = r_pos;
        w_res.list_done      = w_in.end_of_list;
    end

    // Hold the delimiter; the user must write it only while idle, unchecked here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= DELIM_RESET;
        end else if (i_cfg.valid) begin
            r_delim <= i_cfg.payload;
        end
    end

    // Advance list state per accepted character; end of list clears it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_prev <= CH_NUL;
            r_pos  <= '0;
        end else if (w_accept) begin
            if (w_in.end_of_list) begin
                r_ptr  <= '0;
                r_prev <= CH_NUL;
                r_pos  <= '0;
            end else begin
                r_ptr  <= n_ptr;
                r_prev <= w_in.text_char;
                if (r_pos != '1) r_pos <= r_pos + 1'b1;
            end
        end
    end

    bas_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_data  (w_res),
        .o_ready (w_skid_ready),
        .o_out   (o_out)
    );

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= PW'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    a_list_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_in.end_of_list) |=> (r_ptr == '0 && r_pos == '0))
        else $error("list state not cleared after end of list");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.payload.mismatch && o_out.payload.overflow))
        else $error("mismatch and overflow raised together");

    a_boundary_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.payload.piece_boundary) |->
            (o_out.payload.nesting_depth == 5'd0))
        else $error("piece boundary reported inside nesting");

endmodule

// File: hw/rtl/bas_cell.sv
// ----------------------------------------------------------------------------
// bas_cell
// One stack slot: takes the code above on push, the code below on pop.
// ----------------------------------------------------------------------------
module bas_cell
    import bas_pkg::*;
(
    input  logic      i_clk,
    input  t_stack_op i_op,
    input  t_code     i_above,
    input  t_code     i_below,
    output t_code     o_code
);

    t_code r_code;
    t_code n_code;

    always_comb begin
        case (i_op)
            OP_PUSH: n_code = i_above;
            OP_POP:  n_code = i_below;
            default: n_code = r_code;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
    end

    assign o_code = r_code;

endmodule

// File: hw/rtl/bas_skid.sv
// ----------------------------------------------------------------------------
// bas_skid
// Skid-buffered output: the producer runs one request a cycle until it fills.
// ----------------------------------------------------------------------------
module bas_skid
    import bas_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  t_out_item     i_data,
    output logic          o_ready,
    bas_stream_if.source  o_out
);

    logic      r_main_valid;
    logic      r_skid_valid;
    t_out_item r_main;
    t_out_item r_skid;
    logic      w_take;
    logic      w_drain;

    assign o_ready       = !r_skid_valid;
    assign w_take        = i_valid && !r_skid_valid;
    assign w_drain       = r_main_valid && o_out.ready;
    assign o_out.valid   = r_main_valid;
    assign o_out.payload = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_main_valid || w_drain) begin
            // advance: skid first, else the fresh request
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= w_take;
            end
        end else if (w_take) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_valid || w_drain) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (w_take) begin
            r_skid <= i_data;
        end
    end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bracket-aware delimiter splitter.
//
// Characters go in over the input channel and each one gets a result back.
// A predictor in the bench keeps its own copy of the nesting stack, the
// previous character, the index and the delimiter. It works out every result
// when its character is accepted, and a monitor compares what comes back,
// field by field, in order. The stimulus starts with short directed lists:
// field extremes, every bracket and quote, escaped quotes, mismatches and a
// full stack. Random lists follow, nested and mostly well formed, plus noise,
// under six delimiter settings. A last long list runs at full rate on both
// sides. Both sides idle at random, apart from some stretches at full rate.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bas_pkg::*;

    localparam int STACK_DEPTH    = 16;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_CHARS    = 200;
    localparam int LONG_LIST_LEN  = 300;

    logic i_clk;
    logic i_rst_n;

    bas_stream_if #(.T(t_cfg_item)) cfg_if ();
    bas_stream_if #(.T(t_in_item))  in_if ();
    bas_stream_if #(.T(t_out_item)) out_if ();

    bracket_aware_delimiter_split #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_if),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // ------------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    int unsigned cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == TIMEOUT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the splitter's nesting stack,
    // previous character, position counter and delimiter register.
    // ------------------------------------------------------------------------
    t_code       nest_stack [STACK_DEPTH];
    logic [4:0]  nest_depth = '0;
    logic [7:0]  prev_char  = CH_NUL;
    logic [15:0] char_pos   = '0;
    logic [7:0]  delim_reg  = DELIM_RESET;

    // Results still owed by the block, oldest first
    t_out_item   char_results_q [$];
    int unsigned err_count    = 0;
    int unsigned chars_sent   = 0;
    int unsigned tx_gap_max   = 15;
    int unsigned rx_stall_max = 15;

    // Push an opener; refuse it when the stack is full
    function automatic bit push_opener(input t_code code);
        if (nest_depth >= STACK_DEPTH)
            return 1'b0;
        nest_stack[nest_depth] = code;
        nest_depth++;
        return 1'b1;
    endfunction

    function automatic bit top_matches(input t_code code);
        return (nest_depth != 0) && (nest_stack[nest_depth - 1] == code);
    endfunction

    // Work out the result for one character and advance the predictor state
    function automatic t_out_item split_char(input logic [7:0] c, input logic eol);
        t_out_item r;
        t_code     opener;
        r = '0;
        r.char_out = c;
        case (c)
            CH_LSQ, CH_LRND, CH_LCRL: begin
                opener = (c == CH_LSQ) ? CODE_SQUARE :
                         (c == CH_LRND) ? CODE_ROUND : CODE_CURLY;
                r.overflow = !push_opener(opener);
            end
            CH_DQUOTE, CH_SQUOTE: begin
                // A quote straight after a backslash leaves the stack alone
                if (prev_char != CH_BSLASH) begin
                    opener = (c == CH_DQUOTE) ? CODE_DQUOTE : CODE_SQUOTE;
                    if (top_matches(opener))
                        nest_depth--;
                    else
                        r.overflow = !push_opener(opener);
                end
            end
            CH_RSQ, CH_RRND, CH_RCRL: begin
                opener = (c == CH_RSQ) ? CODE_SQUARE :
                         (c == CH_RRND) ? CODE_ROUND : CODE_CURLY;
                if (top_matches(opener))
                    nest_depth--;
                else
                    r.mismatch = 1'b1;
            end
            default: ;
        endcase
        // The depth-zero test sees the stack after this character's update
        r.piece_boundary = (c == delim_reg) && (nest_depth == 0);
        r.nesting_depth  = nest_depth;
        r.char_index     = char_pos;
        r.list_done      = eol;
        if (eol) begin
            nest_depth = '0;
            prev_char  = CH_NUL;
            char_pos   = '0;
        end else begin
            prev_char = c;
            if (char_pos != 16'hFFFF)
                char_pos++;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random back-pressure and the in-order checker.
    // Handshakes are sampled at the falling edge, where every signal has
    // settled for the rising edge that follows.
    // ------------------------------------------------------------------------
    initial begin : rx_stall
        int unsigned stall;
        out_if.ready = 1'b0;
        forever begin
            stall = $urandom_range(0, rx_stall_max);
            if (stall != 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(negedge i_clk); while (!out_if.valid);
            @(posedge i_clk);
        end
    end

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endtask

    always @(negedge i_clk) begin : result_check
        t_out_item want;
        t_out_item got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.payload;
            if (char_results_q.size() == 0) begin
                $error("result request with nothing outstanding: char_out 0x%0h",
                       got.char_out);
                err_count++;
            end else begin
                want = char_results_q.pop_front();
                compare_field("char_out",       want.char_out,       got.char_out);
                compare_field("piece_boundary", want.piece_boundary, got.piece_boundary);
                compare_field("mismatch",       want.mismatch,       got.mismatch);
                compare_field("overflow",       want.overflow,       got.overflow);
                compare_field("nesting_depth",  want.nesting_depth,  got.nesting_depth);
                compare_field("char_index",     want.char_index,     got.char_index);
                compare_field("list_done",      want.list_done,      got.list_done);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side. Every task starts and ends on a rising edge.
    // ------------------------------------------------------------------------

    // Idle for a random gap, offer the character, hold it until taken
    task automatic send_char(input logic [7:0] c, input logic eol);
        int unsigned gap;
        t_in_item    item;
        t_out_item   want;
        gap = $urandom_range(0, tx_gap_max);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item.text_char   = c;
        item.end_of_list = eol;
        in_if.valid   <= 1'b1;
        in_if.payload <= item;
        do @(negedge i_clk); while (!in_if.ready);
        @(posedge i_clk);
        want = split_char(c, eol);
        char_results_q = {char_results_q, want};
        chars_sent++;
    endtask

    // Drop valid and wait until every owed result is back, plus the
    // registered output stage of the block with margin
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (char_results_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Change the delimiter only with the block idle
    task automatic write_delimiter(input logic [7:0] d);
        wait_drained();
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= d;
        do @(negedge i_clk); while (!cfg_if.ready);
        @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        delim_reg = d;
    endtask

    // A list of mostly balanced brackets and quotes with random content
    task automatic send_nested_list();
        logic [7:0]  closers [$];
        logic [7:0]  c;
        int unsigned len;
        int unsigned roll;
        len = $urandom_range(1, 40);
        for (int i = 0; i < len; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 18 && closers.size() < STACK_DEPTH + 2) begin
                case ($urandom_range(0, 4))
                    0: begin c = CH_LSQ;    closers = {closers, CH_RSQ};    end
                    1: begin c = CH_LRND;   closers = {closers, CH_RRND};   end
                    2: begin c = CH_LCRL;   closers = {closers, CH_RCRL};   end
                    3: begin c = CH_DQUOTE; closers = {closers, CH_DQUOTE}; end
                    default: begin c = CH_SQUOTE; closers = {closers, CH_SQUOTE}; end
                endcase
                send_char(c, 1'b0);
            end else if (roll < 36 && closers.size() != 0) begin
                send_char(closers.pop_back(), 1'b0);
            end else if (roll < 44) begin
                // Escaped quote
                send_char(CH_BSLASH, 1'b0);
                send_char($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE, 1'b0);
            end else if (roll < 58) begin
                send_char(delim_reg, 1'b0);
            end else if (roll < 62) begin
                // Stray closer
                case ($urandom_range(0, 2))
                    0:       send_char(CH_RSQ, 1'b0);
                    1:       send_char(CH_RRND, 1'b0);
                    default: send_char(CH_RCRL, 1'b0);
                endcase
            end else if (roll < 68) begin
                send_char(8'($urandom_range(0, 255)), 1'b0);
            end else begin
                send_char(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
            end
        end
        // Usually close what is still open before ending the list
        if ($urandom_range(0, 4) != 0) begin
            while (closers.size() != 0)
                send_char(closers.pop_back(), 1'b0);
        end
        send_char($urandom_range(0, 1) ? delim_reg : 8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Raw bytes with the odd early end of list
    task automatic send_noise_list();
        int unsigned len;
        len = $urandom_range(1, 20);
        for (int i = 0; i < len; i++)
            send_char(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        send_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Field extremes, each bracket and quote, mismatches, escapes, boundaries
    task automatic test_directed();
        logic [7:0] seq [19];
        seq = '{8'h00, 8'hFF, CH_RSQ, DELIM_RESET, CH_LSQ, CH_LRND, DELIM_RESET,
                CH_RCRL, CH_RRND, CH_DQUOTE, CH_BSLASH, CH_DQUOTE, CH_SQUOTE,
                CH_SQUOTE, CH_DQUOTE, CH_RSQ, CH_BSLASH, CH_SQUOTE, DELIM_RESET};
        for (int i = 0; i < 19; i++)
            send_char(seq[i], i == 18);
    endtask

    // Fill the stack, then push a bracket and a quote against it
    task automatic test_full_stack();
        logic [7:0] openers [5];
        openers = '{CH_LSQ, CH_DQUOTE, CH_LRND, CH_SQUOTE, CH_LCRL};
        for (int i = 0; i < STACK_DEPTH; i++)
            send_char(openers[i % 5], 1'b0);
        send_char(CH_LCRL, 1'b0);
        send_char(CH_DQUOTE, 1'b0);
        send_char(CH_RSQ, 1'b0);
        send_char(delim_reg, 1'b1);
    endtask

    // Random lists under several delimiters, some phases at full rate
    task automatic test_random_lists();
        logic [7:0]  phase_delim [RANDOM_PHASES];
        int unsigned phase_end;
        phase_delim = '{DELIM_RESET, 8'h00, 8'hFF, CH_LRND, CH_SQUOTE, 8'h3B};
        phase_delim[RANDOM_PHASES - 1] = 8'($urandom_range(0, 255));
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_delimiter(phase_delim[p]);
            tx_gap_max   = (p % 3 == 2) ? 0 : 15;
            rx_stall_max = (p % 3 == 2) ? 0 : 15;
            phase_end    = chars_sent + PHASE_CHARS;
            while (chars_sent < phase_end) begin
                if ($urandom_range(0, 7) == 0)
                    send_noise_list();
                else
                    send_nested_list();
                // Now and then hold the input until everything is back
                if ($urandom_range(0, 9) == 0)
                    wait_drained();
            end
        end
        tx_gap_max   = 15;
        rx_stall_max = 15;
    endtask

    // One long list with a running index, at full rate on both sides
    task automatic test_long_list();
        write_delimiter(DELIM_RESET);
        tx_gap_max   = 0;
        rx_stall_max = 0;
        for (int i = 0; i < LONG_LIST_LEN; i++) begin
            case ($urandom_range(0, 5))
                0:       send_char(CH_LSQ, 1'b0);
                1:       send_char(CH_RSQ, 1'b0);
                2:       send_char(delim_reg, 1'b0);
                default: send_char(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
            endcase
        end
        send_char(delim_reg, 1'b1);
        tx_gap_max   = 15;
        rx_stall_max = 15;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.payload  = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.payload = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_stack();
        test_random_lists();
        test_long_list();

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/bas_pkg.sv
hw/rtl/bas_stream_if.sv
hw/rtl/bas_cell.sv
hw/rtl/bas_skid.sv
hw/rtl/bracket_aware_delimiter_split.sv
tb/tb_top.sv
